### rtl/obgov_pkg.sv
package obgov_pkg;

    // Stream and configuration port widths
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // Field widths
    localparam int CENTER_W = 16;
    localparam int SIZE_W   = 13;
    localparam int DIST_W   = 15;
    localparam int SPEED_W  = 10;
    localparam int SCORE_W  = 17;
    localparam int PT_W     = 18;   // point coordinate in half-cm
    localparam int STEP_W   = 5;

    localparam logic [SCORE_W-1:0] NO_OBSTACLE = 17'd99900;

    // Rectangle bounds in half-cm
    localparam logic signed [PT_W-1:0] FB_NEAR_H       = 18'sd660;
    localparam logic signed [PT_W-1:0] FB_FAR_H        = 18'sd3660;
    localparam logic signed [PT_W-1:0] FB_HALFW_H      = 18'sd300;
    localparam logic signed [PT_W-1:0] FB_ACROSS_MIN_H = 18'sd260;
    localparam logic signed [PT_W-1:0] LR_NEAR_H       = 18'sd320;
    localparam logic signed [PT_W-1:0] LR_FAR_H        = 18'sd3320;
    localparam logic signed [PT_W-1:0] LR_HALFW_H      = 18'sd650;
    localparam logic signed [PT_W-1:0] LR_ACROSS_MIN_H = 18'sd400;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_DIRECTION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_DISTANCE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_SPEED        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_DISTANCE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_SPEED       = 3'd4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_POINT,
        OP_SCORE,
        OP_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_FINISH
    } op_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_NO_BOX,
        COND_NOT_LAST,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef enum logic [1:0] {
        CF_ZERO,
        CF_POS,
        CF_NEG
    } coef_t;

    typedef struct packed {
        op_t               op;
        coef_t             kx;
        coef_t             ky;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic box_valid;
        logic last;
        logic div_more;
        logic out_busy;
    } status_t;

    typedef struct packed {
        logic [1:0]         region_direction;
        logic [DIST_W-1:0]  far_distance;
        logic [SPEED_W-1:0] far_speed;
        logic [DIST_W-1:0]  near_distance;
        logic [SPEED_W-1:0] near_speed;
    } cfg_t;

endpackage

### rtl/obgov_seq.sv
module obgov_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  obgov_pkg::status_t status,
    output obgov_pkg::ctrl_t   ctrl
);
    import obgov_pkg::*;

    localparam logic [STEP_W-1:0] S_IDLE   = 5'd0;
    localparam logic [STEP_W-1:0] S_FRAME  = 5'd20;
    localparam logic [STEP_W-1:0] S_DIV    = 5'd23;
    localparam logic [STEP_W-1:0] S_WAIT   = 5'd24;
    localparam logic [STEP_W-1:0] S_LAST   = 5'd25;

    function automatic ctrl_t cw(op_t op, coef_t kx, coef_t ky, cond_t cond,
                                 logic [STEP_W-1:0] target);
        ctrl_t c;
        c.op     = op;
        c.kx     = kx;
        c.ky     = ky;
        c.cond   = cond;
        c.target = target;
        return c;
    endfunction

    // Microprogram: two steps per sample point, one per quotient bit
    function automatic ctrl_t ucode(logic [STEP_W-1:0] step);
        ctrl_t c;
        case (step) inside
            5'd0:  c = cw(OP_ACCEPT,   CF_ZERO, CF_ZERO, COND_NO_INPUT, S_IDLE);
            5'd1:  c = cw(OP_NOP,      CF_ZERO, CF_ZERO, COND_NO_BOX,   S_FRAME);
            5'd2:  c = cw(OP_POINT,    CF_NEG,  CF_NEG,  COND_NONE,     S_IDLE);
            5'd4:  c = cw(OP_POINT,    CF_NEG,  CF_ZERO, COND_NONE,     S_IDLE);
            5'd6:  c = cw(OP_POINT,    CF_NEG,  CF_POS,  COND_NONE,     S_IDLE);
            5'd8:  c = cw(OP_POINT,    CF_ZERO, CF_NEG,  COND_NONE,     S_IDLE);
            5'd10: c = cw(OP_POINT,    CF_ZERO, CF_ZERO, COND_NONE,     S_IDLE);
            5'd12: c = cw(OP_POINT,    CF_ZERO, CF_POS,  COND_NONE,     S_IDLE);
            5'd14: c = cw(OP_POINT,    CF_POS,  CF_NEG,  COND_NONE,     S_IDLE);
            5'd16: c = cw(OP_POINT,    CF_POS,  CF_ZERO, COND_NONE,     S_IDLE);
            5'd18: c = cw(OP_POINT,    CF_POS,  CF_POS,  COND_NONE,     S_IDLE);
            5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd13, 5'd15, 5'd17, 5'd19:
                   c = cw(OP_SCORE,    CF_ZERO, CF_ZERO, COND_NONE,     S_IDLE);
            5'd20: c = cw(OP_NOP,      CF_ZERO, CF_ZERO, COND_NOT_LAST, S_IDLE);
            5'd21: c = cw(OP_MUL,      CF_ZERO, CF_ZERO, COND_NONE,     S_IDLE);
            5'd22: c = cw(OP_DIV_INIT, CF_ZERO, CF_ZERO, COND_NONE,     S_IDLE);
            5'd23: c = cw(OP_DIV_STEP, CF_ZERO, CF_ZERO, COND_DIV_MORE, S_DIV);
            5'd24: c = cw(OP_NOP,      CF_ZERO, CF_ZERO, COND_OUT_BUSY, S_WAIT);
            5'd25: c = cw(OP_FINISH,   CF_ZERO, CF_ZERO, COND_ALWAYS,   S_IDLE);
            default: c = cw(OP_NOP,    CF_ZERO, CF_ZERO, COND_ALWAYS,   S_IDLE);
        endcase
        return c;
    endfunction

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              jump;

    assign ctrl = ucode(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NONE:     jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_INPUT: jump = !status.in_valid;
            COND_NO_BOX:   jump = !status.box_valid;
            COND_NOT_LAST: jump = !status.last;
            COND_DIV_MORE: jump = status.div_more;
            COND_OUT_BUSY: jump = status.out_busy;
            default:       jump = 1'b1;
        endcase
        step_next = jump ? ctrl.target : step_reg + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

`ifndef SYNTH
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= S_LAST)
        else $error("step counter left the program");

    a_finish_returns: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == S_LAST |=> step_reg == S_IDLE)
        else $error("finish step did not return to idle");

    a_accept_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == S_IDLE && status.in_valid) |=> step_reg == 5'd1)
        else $error("accepted transaction did not start the program");
`endif

endmodule

### rtl/obgov_dp.sv
module obgov_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  obgov_pkg::ctrl_t                    ctrl,
    input  obgov_pkg::cfg_t                     cfg,
    input  logic                                s_tvalid,
    input  logic [obgov_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                                s_tlast,
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [obgov_pkg::OUT_DATA_W-1:0]    m_tdata,
    output obgov_pkg::status_t                  status
);
    import obgov_pkg::*;

    // Latched item
    logic signed [CENTER_W-1:0] cx_reg, cy_reg;
    logic [SIZE_W-1:0]          sx_reg, sy_reg;
    logic                       box_reg, last_reg;

    // Point and score
    logic signed [PT_W-1:0]     px_reg, py_reg, px_next, py_next;
    logic [SCORE_W-1:0]         min_reg, min_next;

    // Speed interpolation
    logic                       ge_far_reg, le_near_reg;
    logic [DIST_W-1:0]          den_reg;
    logic signed [26:0]         prod_reg;
    logic                       neg_reg;
    logic [DIST_W-1:0]          rem_reg, rem_next;
    logic [SPEED_W-1:0]         quo_reg, quo_next;
    logic [3:0]                 cnt_reg;

    // Output register
    logic                       out_valid_reg;
    logic [SCORE_W-1:0]         out_score_reg;
    logic [SPEED_W-1:0]         out_speed_reg;
    logic                       out_seen_reg;

    logic accept;
    logic fire;

    assign accept = (ctrl.op == OP_ACCEPT) && s_tvalid;
    assign fire   = (ctrl.op == OP_FINISH);

    function automatic logic signed [PT_W-1:0] offset(coef_t k, logic [SIZE_W-1:0] s);
        logic signed [PT_W-1:0] v;
        v = $signed({5'b0, s});
        case (k)
            CF_POS:  return v;
            CF_NEG:  return -v;
            default: return '0;
        endcase
    endfunction

    // Point generation
    always_comb
    begin
        px_next = $signed({cx_reg[CENTER_W-1], cx_reg, 1'b0}) + offset(ctrl.kx, sx_reg);
        py_next = $signed({cy_reg[CENTER_W-1], cy_reg, 1'b0}) + offset(ctrl.ky, sy_reg);
    end

    // Region test and score of the held point
    logic signed [PT_W-1:0] along_src, across_src, a_pos, across_abs;
    logic signed [PT_W-1:0] near_h, far_h, halfw_h, amin_h, along_full;
    logic                   in_rect;
    logic [11:0]            along;
    logic [10:0]            across;
    logic [12:0]            score2;
    logic [11:0]            score;

    always_comb
    begin
        along_src  = cfg.region_direction[1] ? py_reg : px_reg;
        across_src = cfg.region_direction[1] ? px_reg : py_reg;
        a_pos      = cfg.region_direction[0] ? -along_src : along_src;
        near_h     = cfg.region_direction[1] ? LR_NEAR_H : FB_NEAR_H;
        far_h      = cfg.region_direction[1] ? LR_FAR_H : FB_FAR_H;
        halfw_h    = cfg.region_direction[1] ? LR_HALFW_H : FB_HALFW_H;
        amin_h     = cfg.region_direction[1] ? LR_ACROSS_MIN_H : FB_ACROSS_MIN_H;
        in_rect    = (a_pos >= near_h) && (a_pos <= far_h)
                  && (across_src >= -halfw_h) && (across_src <= halfw_h);
        along_full = a_pos - near_h;
        along      = along_full[11:0];
        across_abs = (across_src < 0) ? -across_src : across_src;
        across     = (across_abs < amin_h) ? 11'd0 : across_abs[10:0];
        score2     = {1'b0, along} + {1'b0, across, 1'b0};
        score      = score2[12:1];
    end

    // Division step
    logic [DIST_W:0] trial;
    logic            take;
    always_comb
    begin
        trial    = {rem_reg, quo_reg[SPEED_W-1]};
        take     = trial >= {1'b0, den_reg};
        rem_next = take ? DIST_W'(trial - {1'b0, den_reg}) : trial[DIST_W-1:0];
        quo_next = {quo_reg[SPEED_W-2:0], take};
    end

    // Speed selection at finish
    logic [SPEED_W:0]   interp;
    logic [SPEED_W-1:0] speed;
    always_comb
    begin
        if (neg_reg)
        begin
            interp = {1'b0, cfg.near_speed}
                   - ({1'b0, quo_reg} + {{SPEED_W{1'b0}}, (rem_reg != '0)});
        end
        else
        begin
            interp = {1'b0, cfg.near_speed} + {1'b0, quo_reg};
        end
        if (ge_far_reg)
        begin
            speed = cfg.far_speed;
        end
        else if (le_near_reg)
        begin
            speed = cfg.near_speed;
        end
        else
        begin
            speed = interp[SPEED_W-1:0];
        end
    end

    always_comb
    begin
        min_next = min_reg;
        if (ctrl.op == OP_SCORE && in_rect && ({5'b0, score} < min_reg))
        begin
            min_next = {5'b0, score};
        end
        else if (fire)
        begin
            min_next = NO_OBSTACLE;
        end
    end

    // Payload registers
    logic [DIST_W-1:0]  dd;
    logic signed [10:0] ds;
    logic [26:0]        mag;
    assign dd  = min_reg[DIST_W-1:0] - cfg.near_distance;
    assign ds  = $signed({1'b0, cfg.far_speed}) - $signed({1'b0, cfg.near_speed});
    assign mag = prod_reg[26] ? 27'(-prod_reg) : prod_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg   <= $signed(s_tdata[15:0]);
            cy_reg   <= $signed(s_tdata[31:16]);
            sx_reg   <= s_tdata[44:32];
            sy_reg   <= s_tdata[57:45];
            box_reg  <= s_tuser;
            last_reg <= s_tlast;
        end
        if (ctrl.op == OP_POINT)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (ctrl.op == OP_MUL)
        begin
            ge_far_reg  <= min_reg >= {2'b0, cfg.far_distance};
            le_near_reg <= min_reg <= {2'b0, cfg.near_distance};
            den_reg     <= cfg.far_distance - cfg.near_distance;
            prod_reg    <= $signed({1'b0, dd}) * ds;
        end
        if (ctrl.op == OP_DIV_INIT)
        begin
            neg_reg <= prod_reg[26];
            rem_reg <= mag[24:10];
            quo_reg <= mag[9:0];
        end
        if (ctrl.op == OP_DIV_STEP)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (fire)
        begin
            out_score_reg <= min_reg;
            out_speed_reg <= speed;
            out_seen_reg  <= (min_reg != NO_OBSTACLE);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= NO_OBSTACLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            min_reg <= min_next;
            if (ctrl.op == OP_DIV_INIT)
            begin
                cnt_reg <= 4'd9;
            end
            else if (ctrl.op == OP_DIV_STEP && cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 4'd1;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_seen_reg, out_speed_reg, out_score_reg};

    assign status.in_valid  = s_tvalid;
    assign status.box_valid = box_reg;
    assign status.last      = last_reg;
    assign status.div_more  = (cnt_reg != '0);
    assign status.out_busy  = out_valid_reg && !m_tready;

`ifndef SYNTH
    a_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
        min_reg <= NO_OBSTACLE)
        else $error("running minimum above no-obstacle value");

    a_min_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> min_reg == NO_OBSTACLE)
        else $error("running minimum not cleared after frame result");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("frame result not presented");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(out_valid_reg && !m_tready))
        else $error("result overwrote a pending transaction");
`endif

endmodule

### rtl/obstacle_box_speed_governor.sv
// Obstacle box speed governor. Each input transaction carries at most one
// obstacle box (tuser = box present, tlast = end of frame); nine sample points
// of the box are tested against the detection rectangle chosen by
// region_direction and the smallest score (along + 2 * across) / 2 is kept. On a
// frame end one result transaction gives that minimum (99900 when empty), a
// speed limit interpolated between the near and far settings, and a seen
// flag; the minimum then clears. A microprogrammed sequencer drives the
// datapath: two steps per sample point and one step per quotient bit of the
// 10-bit interpolation divide. The output register decouples the sides: new
// input is accepted while a result waits, and the finish step stalls only if
// a previous result is still pending. Configure only while the block is idle.
module obstacle_box_speed_governor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] box_center_x, [31:16] box_center_y, [44:32] box_size_x,
    // [57:45] box_size_y, [63:58] zero
    input  logic [obgov_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                                s_tlast,   // frame_end
    input  logic                                s_tuser,   // box_valid
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [16:0] nearest_score, [26:17] speed_limit, [27] obstacle_seen, [31:28] zero
    output logic [obgov_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [obgov_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [obgov_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import obgov_pkg::*;

    cfg_t    cfg_reg;
    ctrl_t   ctrl;
    status_t status;
    logic    cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign s_tready  = (ctrl.op == OP_ACCEPT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.region_direction <= 2'd0;
            cfg_reg.far_distance     <= 15'd1500;
            cfg_reg.far_speed        <= 10'd300;
            cfg_reg.near_distance    <= 15'd250;
            cfg_reg.near_speed       <= 10'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REGION_DIRECTION: cfg_reg.region_direction <= cfg_data[1:0];
                CFG_FAR_DISTANCE:     cfg_reg.far_distance     <= cfg_data;
                CFG_FAR_SPEED:        cfg_reg.far_speed        <= cfg_data[SPEED_W-1:0];
                CFG_NEAR_DISTANCE:    cfg_reg.near_distance    <= cfg_data;
                CFG_NEAR_SPEED:       cfg_reg.near_speed       <= cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    obgov_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    obgov_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .status   (status)
    );

endmodule

### tb/tb_obstacle_box_speed_governor.sv
module tb_obstacle_box_speed_governor;
    import obgov_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;
    localparam int MAX_GAP       = 50;

    localparam int DIR_FRONT = 0;
    localparam int DIR_BACK  = 1;
    localparam int DIR_LEFT  = 2;
    localparam int DIR_RIGHT = 3;

    localparam int FB_NEAR       = FB_NEAR_H;
    localparam int FB_FAR        = FB_FAR_H;
    localparam int FB_HALFW      = FB_HALFW_H;
    localparam int FB_ACROSS_MIN = FB_ACROSS_MIN_H;
    localparam int LR_NEAR       = LR_NEAR_H;
    localparam int LR_FAR        = LR_FAR_H;
    localparam int LR_HALFW      = LR_HALFW_H;
    localparam int LR_ACROSS_MIN = LR_ACROSS_MIN_H;

    typedef struct {
        logic [SCORE_W-1:0] score;
        logic [SPEED_W-1:0] speed;
        logic               seen;
    } frame_verdict_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Governor state as the block should hold it
    int region_dir;
    int far_dist;
    int far_spd;
    int near_dist;
    int near_spd;
    int frame_min;

    frame_verdict_t verdicts_due[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int fail_count;
    int stall_cycles;

    obstacle_box_speed_governor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic bit count_failure();
        fail_count++;
        return fail_count <= MAX_REPORTS;
    endfunction

    // Score one sample point given in half-cm; 0 when it lies outside the rectangle
    function automatic bit point_score(input int px, input int py, output int score);
        int ax;
        int ay;
        int along;
        int across;
        score = 0;
        if (region_dir == DIR_FRONT || region_dir == DIR_BACK)
        begin
            ax = (region_dir == DIR_FRONT) ? px : -px;
            if (ax < FB_NEAR || ax > FB_FAR || py < -FB_HALFW || py > FB_HALFW)
                return 1'b0;
            along  = ax - FB_NEAR;
            across = (py < 0) ? -py : py;
            if (across < FB_ACROSS_MIN)
                across = 0;
        end
        else
        begin
            ay = (region_dir == DIR_LEFT) ? py : -py;
            if (ay < LR_NEAR || ay > LR_FAR || px < -LR_HALFW || px > LR_HALFW)
                return 1'b0;
            along  = ay - LR_NEAR;
            across = (px < 0) ? -px : px;
            if (across < LR_ACROSS_MIN)
                across = 0;
        end
        score = (along + 2 * across) / 2;
        return 1'b1;
    endfunction

    function automatic logic [SPEED_W-1:0] speed_for_score(input int d);
        longint num;
        longint den;
        longint q;
        if (d >= far_dist)
            return SPEED_W'(far_spd);
        if (d <= near_dist)
            return SPEED_W'(near_spd);
        num = (longint'(d) - near_dist) * (longint'(far_spd) - near_spd);
        den = longint'(far_dist) - near_dist;
        // round down (toward minus infinity) on both signs of the slope
        if (num >= 0)
            q = near_spd + num / den;
        else
            q = near_spd - ((-num) + den - 1) / den;
        return q[SPEED_W-1:0];
    endfunction

    function automatic void fold_item(input bit box, input bit last,
                                      input logic signed [CENTER_W-1:0] cx,
                                      input logic signed [CENTER_W-1:0] cy,
                                      input logic [SIZE_W-1:0] sx,
                                      input logic [SIZE_W-1:0] sy);
        int cxi;
        int cyi;
        int sxi;
        int syi;
        int s;
        frame_verdict_t v;
        cxi = cx;
        cyi = cy;
        sxi = sx;
        syi = sy;
        if (box)
        begin
            for (int kx = -1; kx <= 1; kx++)
            begin
                for (int ky = -1; ky <= 1; ky++)
                begin
                    if (point_score(2 * cxi + kx * sxi, 2 * cyi + ky * syi, s)
                        && s < frame_min)
                        frame_min = s;
                end
            end
        end
        if (last)
        begin
            v.score = SCORE_W'(frame_min);
            v.speed = speed_for_score(frame_min);
            v.seen  = (frame_min != int'(NO_OBSTACLE));
            verdicts_due.insert(verdicts_due.size(), v);
            frame_min = int'(NO_OBSTACLE);
        end
    endfunction

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin : check_result
        frame_verdict_t want;
        if (m_tvalid && m_tready)
        begin
            if (verdicts_due.size() == 0)
            begin
                if (count_failure())
                    $display("unexpected result transaction: data %h", m_tdata);
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (m_tdata[SCORE_W-1:0] !== want.score
                    || m_tdata[SCORE_W +: SPEED_W] !== want.speed
                    || m_tdata[SCORE_W + SPEED_W] !== want.seen)
                begin
                    if (count_failure())
                        $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 want.score, want.speed, want.seen, m_tdata[SCORE_W-1:0],
                                 m_tdata[SCORE_W +: SPEED_W], m_tdata[SCORE_W + SPEED_W]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_item(input bit box, input bit last,
                             input logic signed [CENTER_W-1:0] cx,
                             input logic signed [CENTER_W-1:0] cy,
                             input logic [SIZE_W-1:0] sx,
                             input logic [SIZE_W-1:0] sy);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < MAX_GAP)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= box;
        s_tlast  <= last;
        s_tdata  <= {{(IN_DATA_W - 2 * CENTER_W - 2 * SIZE_W){1'b0}}, sy, sx, cy, cx};
        do @(posedge clk); while (!s_tready);
        fold_item(box, last, cx, cy, sx, sy);
    endtask

    task automatic await_results();
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    // Drain, then give a trailing box time to finish before touching registers
    task automatic settle();
        await_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_REGION_DIRECTION: region_dir = int'(val[1:0]);
            CFG_FAR_DISTANCE:     far_dist   = int'(val[DIST_W-1:0]);
            CFG_FAR_SPEED:        far_spd    = int'(val[SPEED_W-1:0]);
            CFG_NEAR_DISTANCE:    near_dist  = int'(val[DIST_W-1:0]);
            CFG_NEAR_SPEED:       near_spd   = int'(val[SPEED_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int dir, input int fd, input int fs,
                                  input int nd, input int ns);
        settle();
        cfg_write(CFG_REGION_DIRECTION, CFG_DATA_W'(dir));
        cfg_write(CFG_FAR_DISTANCE, CFG_DATA_W'(fd));
        cfg_write(CFG_FAR_SPEED, CFG_DATA_W'(fs));
        cfg_write(CFG_NEAR_DISTANCE, CFG_DATA_W'(nd));
        cfg_write(CFG_NEAR_SPEED, CFG_DATA_W'(ns));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_box(output logic signed [CENTER_W-1:0] cx,
                              output logic signed [CENTER_W-1:0] cy,
                              output logic [SIZE_W-1:0] sx,
                              output logic [SIZE_W-1:0] sy);
        int pick;
        int along;
        int lat;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            // aim at the active rectangle, with some margin around its edges
            along = int'($urandom_range(1600)) - 50;
            lat   = int'($urandom_range(800)) - 400;
            case (region_dir)
                DIR_FRONT:
                begin
                    cx = CENTER_W'(FB_NEAR / 2 + along);
                    cy = CENTER_W'(lat);
                end
                DIR_BACK:
                begin
                    cx = CENTER_W'(-(FB_NEAR / 2 + along));
                    cy = CENTER_W'(lat);
                end
                DIR_LEFT:
                begin
                    cy = CENTER_W'(LR_NEAR / 2 + along);
                    cx = CENTER_W'(lat);
                end
                default:
                begin
                    cy = CENTER_W'(-(LR_NEAR / 2 + along));
                    cx = CENTER_W'(lat);
                end
            endcase
            sx = SIZE_W'(($urandom_range(3) == 0) ? $urandom_range(2000) : $urandom_range(300));
            sy = SIZE_W'(($urandom_range(3) == 0) ? $urandom_range(2000) : $urandom_range(300));
        end
        else if (pick < 85)
        begin
            cx = CENTER_W'(int'($urandom_range(4200)) - 2100);
            cy = CENTER_W'(int'($urandom_range(4200)) - 2100);
            sx = SIZE_W'($urandom_range(3000));
            sy = SIZE_W'($urandom_range(3000));
        end
        else
        begin
            cx = CENTER_W'($urandom);
            cy = CENTER_W'($urandom);
            sx = SIZE_W'($urandom);
            sy = SIZE_W'($urandom);
        end
    endtask

    task automatic random_frames(input int n_items);
        int sent;
        int len;
        bit box;
        logic signed [CENTER_W-1:0] cx;
        logic signed [CENTER_W-1:0] cy;
        logic [SIZE_W-1:0] sx;
        logic [SIZE_W-1:0] sy;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(1, 5);
            for (int j = 0; j < len; j++)
            begin
                box = ($urandom_range(9) != 0);
                random_box(cx, cy, sx, sy);
                send_item(box, j == len - 1, cx, cy, sx, sy);
            end
            sent += len;
        end
    endtask

    function automatic int random_distance();
        case ($urandom_range(9))
            0:       return 0;
            1:       return (1 << CFG_DATA_W) - 1;
            default: return int'($urandom_range(2400));
        endcase
    endfunction

    function automatic int random_speed();
        case ($urandom_range(9))
            0:       return 0;
            1:       return (1 << SPEED_W) - 1;
            2:       return int'($urandom);    // upper bits are dropped by the register
            default: return int'($urandom_range((1 << SPEED_W) - 1));
        endcase
    endfunction

    task automatic test_empty_and_ignored();
        send_item(1'b0, 1'b1, 0, 0, 0, 0);
        send_item(1'b0, 1'b1, -32768, 32767, 8191, 8191);
        send_item(1'b0, 1'b0, 12345, -1, 5, 7);
        send_item(1'b1, 1'b1, 330, 0, 0, 0);
    endtask

    task automatic test_front_scoring();
        send_item(1'b1, 1'b1, 1830, 150, 0, 0);
        send_item(1'b1, 1'b1, 329, 0, 0, 0);
        send_item(1'b1, 1'b0, 800, 100, 0, 0);
        send_item(1'b1, 1'b0, 600, 140, 0, 0);
        send_item(1'b1, 1'b1, 1000, 0, 8191, 8191);
        send_item(1'b1, 1'b0, 32767, -32768, 8191, 0);
        send_item(1'b1, 1'b1, -32768, 32767, 0, 8191);
        send_item(1'b1, 1'b1, 330, 0, 1, 1);
    endtask

    // Hit each rectangle at and just under the across threshold, and at its edges
    task automatic test_each_direction();
        apply_settings(DIR_FRONT, 1500, 300, 250, 0);
        send_item(1'b1, 1'b0, 530, 130, 0, 0);
        send_item(1'b1, 1'b1, 530, -129, 2, 2);
        apply_settings(DIR_BACK, 1500, 300, 250, 0);
        send_item(1'b1, 1'b0, -530, -130, 0, 0);
        send_item(1'b1, 1'b1, -1830, 129, 0, 3);
        apply_settings(DIR_LEFT, 1500, 300, 250, 0);
        send_item(1'b1, 1'b0, 200, 260, 0, 0);
        send_item(1'b1, 1'b1, -199, 1660, 3, 0);
        apply_settings(DIR_RIGHT, 1500, 300, 250, 0);
        send_item(1'b1, 1'b0, -200, -260, 0, 0);
        send_item(1'b1, 1'b1, 325, -160, 1, 1);
    endtask

    task automatic test_register_extremes();
        apply_settings(DIR_FRONT, 0, 0, 0, 0);
        random_frames(40);
        apply_settings(DIR_BACK, (1 << CFG_DATA_W) - 1, (1 << SPEED_W) - 1,
                       (1 << CFG_DATA_W) - 1, 0);
        random_frames(40);
        // far distance below near distance
        apply_settings(DIR_LEFT, 100, (1 << SPEED_W) - 1, 2000, 0);
        random_frames(40);
        // falling slope: far speed below near speed
        apply_settings(DIR_RIGHT, 2000, 0, 0, (1 << SPEED_W) - 1);
        random_frames(40);
        // full-width writes get masked; spare indexes are ignored
        settle();
        cfg_write(CFG_REGION_DIRECTION, 15'h7FFE);
        cfg_write(CFG_FAR_SPEED, 15'h7FFF);
        cfg_write(CFG_NEAR_SPEED, 15'h7C05);
        for (int i = CFG_NEAR_SPEED + 1; i < (1 << CFG_IDX_W); i++)
            cfg_write(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        random_frames(40);
    endtask

    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        int sent;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_items)
        begin
            apply_settings(int'($urandom), random_distance(), random_speed(),
                           random_distance(), random_speed());
            random_frames(57);
            // hold the sender until every frame result is back
            await_results();
            random_frames(57);
            sent += 114;
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        tx_idle_pct  = 11;
        rx_idle_pct  = 61;
        region_dir = DIR_FRONT;
        far_dist   = 1500;
        far_spd    = 300;
        near_dist  = 250;
        near_spd   = 0;
        frame_min  = int'(NO_OBSTACLE);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_ignored();
        test_front_scoring();
        test_each_direction();
        test_register_extremes();
        test_random_traffic(570, 11, 61);
        test_random_traffic(570, 61, 11);
        test_random_traffic(570, 0, 0);

        settle();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
